[rtl/ird_pkg.sv]
// ird_pkg: shared types and constants for the input-restricted deque
// holds the request/result transfer structs, request and status codes
// no dependencies
package ird_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int DATA_W    = 32;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 2;
  localparam int OCC_W     = 4;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT_REAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE_FRONT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE_REAR  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] value;
  } req_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] removed_data;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_full;
    logic                     is_empty;
  } rsp_out_t;

endpackage

[rtl/ird_store.sv]
// ird_store: element storage of the deque, one write and one read port
// read data is registered, valid in the cycle after rd_en
// depends on ird_pkg for the data width
module ird_store #(
  parameter int DEPTH = ird_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [ird_pkg::DATA_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [ird_pkg::DATA_W-1:0] rd_data
);
  import ird_pkg::*;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/input_restricted_deque.sv]
// input_restricted_deque: circular-buffer deque, insert at rear, remove at front or rear
// top level with pointer control and result register; instantiates ird_store
// depends on ird_pkg
//
//   channel  | direction | ports                          | payload
//   ---------+-----------+--------------------------------+-----------
//   request  | in        | in_valid, in_ready, in_data    | req_in_t
//   result   | out       | out_valid, out_ready, out_data | rsp_out_t
//
// an insert, a rejected request or an unused code gives its result in the cycle after
// the transfer; a successful delete waits in S_READ for the store's registered read first
// a new request is taken only in the idle state and when the result register
// is empty or being drained in the same cycle
// reset clears pointers, empty flag and control; store contents need no clearing
// a stalled result holds the block, no request is taken behind it
module input_restricted_deque #(
  parameter int DEPTH = ird_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ird_pkg::req_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ird_pkg::rsp_out_t out_data
);
  import ird_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t   state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic     empty_r, empty_nxt;
  logic     out_valid_r, out_valid_nxt;
  rsp_out_t out_data_r, out_data_nxt;
  rsp_out_t pend_r, pend_nxt;

  logic          accept;
  logic          full;
  logic          need_read;
  logic [AW-1:0] head_inc, tail_inc, tail_dec;
  logic [AW-1:0] h_new, t_new;
  logic          e_new;
  logic [STAT_W-1:0] status;
  logic [CW-1:0] cnt;
  logic [CW+OCC_W-1:0] cnt_ext;
  rsp_out_t      rsp;

  logic              wr_en, rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  // pointer arithmetic, wraps at any depth
  assign full     = !empty_r && (head_r == tail_r);
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? LAST_IDX : tail_r - 1'b1;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // decode the request against the current pointers
  always_comb begin
    h_new     = head_r;
    t_new     = tail_r;
    e_new     = empty_r;
    status    = STAT_DONE;
    need_read = 1'b0;
    rd_addr   = head_r;
    case (in_data.req_type)
      REQ_INSERT_REAR: begin
        if (full) begin
          status = STAT_FULL;
        end else begin
          t_new = tail_inc;
          e_new = 1'b0;
        end
      end
      REQ_DELETE_FRONT: begin
        if (empty_r) begin
          status = STAT_EMPTY;
        end else begin
          need_read = 1'b1;
          rd_addr   = head_r;
          h_new     = head_inc;
          // last word gone: back to the reset position
          if (head_inc == tail_r) begin
            h_new = '0;
            t_new = '0;
            e_new = 1'b1;
          end
        end
      end
      REQ_DELETE_REAR: begin
        if (empty_r) begin
          status = STAT_EMPTY;
        end else begin
          need_read = 1'b1;
          rd_addr   = tail_dec;
          t_new     = tail_dec;
          if (tail_dec == head_r) begin
            h_new = '0;
            t_new = '0;
            e_new = 1'b1;
          end
        end
      end
      default: begin
        // unused code leaves the state alone and reports done
      end
    endcase
  end

  // occupancy after the request
  always_comb begin
    if (e_new) begin
      cnt = '0;
    end else if (t_new > h_new) begin
      cnt = CW'(t_new) - CW'(h_new);
    end else begin
      cnt = CW'(DEPTH) - CW'(h_new) + CW'(t_new);
    end
  end

  assign cnt_ext = {{OCC_W{1'b0}}, cnt};

  always_comb begin
    rsp.status       = status;
    rsp.removed_data = '0;
    rsp.occupancy    = cnt_ext[OCC_W-1:0];
    rsp.is_full      = !e_new && (h_new == t_new);
    rsp.is_empty     = e_new;
  end

  assign wr_en = accept && (in_data.req_type == REQ_INSERT_REAR) && !full;
  assign rd_en = accept && need_read;

  // next state of control and result register
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    empty_nxt     = empty_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      head_nxt  = h_new;
      tail_nxt  = t_new;
      empty_nxt = e_new;
      if (need_read) begin
        // removed word arrives from the store next cycle
        pend_nxt  = rsp;
        state_nxt = S_READ;
      end else begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = rsp;
      end
    end else if (state_r == S_READ) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt              = pend_r;
      out_data_nxt.removed_data = rd_data;
      state_nxt                 = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ird_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (in_data.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

[rtl/ird_checker.sv]
// ird_checker: port-level assertions for the input-restricted deque
// bound to input_restricted_deque; depends on ird_pkg
module ird_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input ird_pkg::req_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input ird_pkg::rsp_out_t out_data
);
  import ird_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a waiting request stays offered with the same payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request changed while waiting");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |-> out_data.occupancy == '0)
    else $error("empty with nonzero occupancy");

  a_reject_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STAT_DONE) |-> out_data.removed_data == '0)
    else $error("rejected request returned data");

  a_reject_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_FULL) |-> out_data.is_full)
    else $error("full rejection without full flag");

endmodule

bind input_restricted_deque ird_checker u_ird_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/tb_input_restricted_deque.sv]
// tb_input_restricted_deque: self-checking testbench for the input-restricted deque
// drives request transfers, predicts every result and checks it field by field
// depends on ird_pkg and input_restricted_deque
module tb_input_restricted_deque;
  import ird_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int TOTAL_ITEMS  = 1050;
  localparam int PHASE1_END   = 370;   // sender idles rarely, receiver often
  localparam int PHASE2_END   = 720;   // the other way round, then no idling
  localparam int HOLD_AT      = 150;   // long receiver hold-off starts here
  localparam int HOLD_CYCLES  = 48;
  localparam int PAUSE_AT     = 600;   // sender drains the block here
  localparam int STALL_LIMIT  = 2000;  // cycles with no transfer at all
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 10;

  // code that the block must treat as a no-op
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  req_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rsp_out_t out_data;

  input_restricted_deque #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // requests waiting to be offered, and results the deque still owes us
  req_in_t  req_backlog[$];
  rsp_out_t owed_results[$];

  // shadow copy of the deque contents and pointers
  logic [DATA_W-1:0] shadow_slots[DEPTH];
  int unsigned       shadow_front = 0;
  int unsigned       shadow_rear  = 0;
  bit                shadow_empty = 1'b1;

  int  sent_cnt    = 0;
  int  mismatches  = 0;
  int  idle_cycles = 0;
  int  hold_left   = 0;
  bit  hold_done   = 1'b0;
  bit  timed_out;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // full means something is stored and the pointers have met
  function automatic bit shadow_full();
    return !shadow_empty && shadow_front == shadow_rear;
  endfunction

  // taking the last word out parks both pointers at zero
  function automatic void settle_after_removal();
    if (shadow_front == shadow_rear) begin
      shadow_empty = 1'b1;
      shadow_front = 0;
      shadow_rear  = 0;
    end
  endfunction

  // apply one accepted request to the shadow deque and return its result
  function automatic rsp_out_t deque_apply(input req_in_t r);
    rsp_out_t res;
    int unsigned occ;
    res        = '0;
    res.status = STAT_DONE;
    case (r.req_type)
      REQ_INSERT_REAR: begin
        if (shadow_full()) begin
          res.status = STAT_FULL;
        end else begin
          shadow_slots[shadow_rear] = r.value;
          shadow_rear  = (shadow_rear + 1) % DEPTH;
          shadow_empty = 1'b0;
        end
      end
      REQ_DELETE_FRONT: begin
        if (shadow_empty) begin
          res.status = STAT_EMPTY;
        end else begin
          res.removed_data = shadow_slots[shadow_front];
          shadow_front = (shadow_front + 1) % DEPTH;
          settle_after_removal();
        end
      end
      REQ_DELETE_REAR: begin
        if (shadow_empty) begin
          res.status = STAT_EMPTY;
        end else begin
          shadow_rear = (shadow_rear == 0) ? DEPTH - 1 : shadow_rear - 1;
          res.removed_data = shadow_slots[shadow_rear];
          settle_after_removal();
        end
      end
      default: ;  // unused code leaves everything alone
    endcase
    if (shadow_empty)
      occ = 0;
    else if (shadow_rear > shadow_front)
      occ = shadow_rear - shadow_front;
    else
      occ = DEPTH - shadow_front + shadow_rear;
    res.occupancy = occ[OCC_W-1:0];
    res.is_full   = shadow_full();
    res.is_empty  = shadow_empty;
    return res;
  endfunction

  // idle odds per phase, in percent
  function automatic int sender_idle_pct();
    if (sent_cnt < PHASE1_END) return 14;
    if (sent_cnt < PHASE2_END) return 54;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (sent_cnt < PHASE1_END) return 54;
    if (sent_cnt < PHASE2_END) return 14;
    return 0;
  endfunction

  task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] word);
    req_in_t r;
    r.req_type = kind;
    r.value    = word;
    req_backlog.push_back(r);
  endtask

  // compare one result transfer with the oldest owed result
  task automatic check_result(input rsp_out_t got);
    rsp_out_t want;
    if (owed_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected result: status=%0d data=%0d occ=%0d full=%0b empty=%0b",
                 got.status, got.removed_data, got.occupancy, got.is_full, got.is_empty);
    end else begin
      want = owed_results.pop_front();
      if (got.status !== want.status || got.removed_data !== want.removed_data ||
          got.occupancy !== want.occupancy || got.is_full !== want.is_full ||
          got.is_empty !== want.is_empty) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: exp status=%0d data=%0d occ=%0d full=%0b empty=%0b | %s%0d %0d %0d %0b %0b",
                   want.status, want.removed_data, want.occupancy, want.is_full,
                   want.is_empty, "act ", got.status, got.removed_data,
                   got.occupancy, got.is_full, got.is_empty);
      end
    end
  endtask

  // driver: predict on each request transfer, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        owed_results.push_back(deque_apply(in_data));
        sent_cnt++;
      end
      if (in_valid && !in_ready) begin
        // offer stands, payload unchanged
      end else if (req_backlog.size() != 0 &&
                   !(sent_cnt == PAUSE_AT && owed_results.size() != 0) &&
                   $urandom_range(0, 99) >= sender_idle_pct()) begin
        in_valid <= 1'b1;
        in_data  <= req_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check result transfers and throttle out_ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        check_result(out_data);
      // one long hold-off so the result register backs up into the input
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
      end
    end
  end

  // watchdog: cycles since the last transfer on either channel
  always @(posedge clk) begin
    if (!rst_n)
      idle_cycles <= 0;
    else if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int unsigned seg_len;
    int unsigned insert_pct;
    int unsigned roll;
    logic [DATA_W-1:0] word;

    // directed: removals and unused code on an empty deque
    queue_req(REQ_DELETE_FRONT, $urandom);
    queue_req(REQ_DELETE_REAR, $urandom);
    queue_req(REQ_UNUSED, $urandom);
    // fill to the brim with extreme words
    queue_req(REQ_INSERT_REAR, 32'h7FFF_FFFF);
    queue_req(REQ_INSERT_REAR, 32'h8000_0000);
    queue_req(REQ_INSERT_REAR, 32'h0000_0000);
    queue_req(REQ_INSERT_REAR, 32'hFFFF_FFFF);
    queue_req(REQ_INSERT_REAR, 32'h0000_0001);
    queue_req(REQ_INSERT_REAR, 32'hAAAA_AAAA);
    queue_req(REQ_INSERT_REAR, 32'h5555_5555);
    queue_req(REQ_INSERT_REAR, $urandom);
    // insert into a full deque is refused, unused code on a full deque
    queue_req(REQ_INSERT_REAR, $urandom);
    queue_req(REQ_UNUSED, $urandom);
    // take from both ends, then wrap the rear pointer
    queue_req(REQ_DELETE_FRONT, $urandom);
    queue_req(REQ_DELETE_REAR, $urandom);
    queue_req(REQ_INSERT_REAR, $urandom);
    // empty it out from alternating ends, the last removal resets pointers
    for (int i = 0; i < 7; i++)
      queue_req((i % 2 == 0) ? REQ_DELETE_REAR : REQ_DELETE_FRONT, $urandom);
    // single word, taken from the rear
    queue_req(REQ_INSERT_REAR, $urandom);
    queue_req(REQ_DELETE_REAR, $urandom);

    // random: segments that lean toward filling, draining or neither, so the
    // deque keeps swinging between empty and full
    while (req_backlog.size() < TOTAL_ITEMS) begin
      seg_len = $urandom_range(6, 20);
      case ($urandom_range(0, 2))
        0:       insert_pct = 75;
        1:       insert_pct = 25;
        default: insert_pct = 50;
      endcase
      for (int i = 0; i < seg_len; i++) begin
        roll = $urandom_range(0, 99);
        word = $urandom;
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0:       word = 32'h7FFF_FFFF;
            1:       word = 32'h8000_0000;
            2:       word = 32'h0000_0000;
            default: word = 32'hFFFF_FFFF;
          endcase
        end
        if (roll < 3)
          queue_req(REQ_UNUSED, word);
        else if (roll < 3 + insert_pct)
          queue_req(REQ_INSERT_REAR, word);
        else
          queue_req($urandom_range(0, 1) ? REQ_DELETE_FRONT : REQ_DELETE_REAR, word);
      end
    end

    // synchronous reset, held at the start
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // run until every request is taken and every result is back
    @(negedge clk);
    while ((req_backlog.size() != 0 || in_valid || owed_results.size() != 0) &&
           idle_cycles < STALL_LIMIT)
      @(negedge clk);
    timed_out = (idle_cycles >= STALL_LIMIT);

    if (timed_out) begin
      $display("TB_ERROR");
    end else begin
      // keep clocking to catch any stray result
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (mismatches == 0 && owed_results.size() == 0)
        $display("TB_OK");
      else
        $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ird_pkg.sv
rtl/ird_store.sv
rtl/input_restricted_deque.sv
rtl/ird_checker.sv
tb/tb_input_restricted_deque.sv
